### sv/rgb_median_window_filter_macros.svh
// ----------------------------------------------------------------------------
// rgb median window filter assertion macros
// short forms for the concurrent checks of the filter top level
// ----------------------------------------------------------------------------
`ifndef RGB_MEDIAN_WINDOW_FILTER_MACROS_SVH
`define RGB_MEDIAN_WINDOW_FILTER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define RMWF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define RMWF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/rmwf_pkg.sv
// ----------------------------------------------------------------------------
// rgb median window filter package
// shared widths, payload structs, register indexes and control types
// ----------------------------------------------------------------------------
package rmwf_pkg;

    localparam int CHAN_W           = 8;
    localparam int PIXEL_W          = 3 * CHAN_W;
    localparam int ROW_W            = 12;
    localparam int OUT_COL_W        = 11;
    localparam int WIDTH_REG_W      = 12;
    localparam int HEIGHT_REG_W     = 13;
    localparam int SIZE_W           = 13;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_INDEX_W      = 1;
    localparam int HEIGHT_LIMIT     = 4096;
    localparam int WIDTH_RESET      = 640;
    localparam int HEIGHT_RESET     = 480;
    localparam int DEFAULT_WINDOW    = 5;
    localparam int DEFAULT_MAX_WIDTH = 2048;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] pixel_red;
        logic [CHAN_W-1:0] pixel_green;
        logic [CHAN_W-1:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    median_red;
        logic [CHAN_W-1:0]    median_green;
        logic [CHAN_W-1:0]    median_blue;
        logic [ROW_W-1:0]     out_row;
        logic [OUT_COL_W-1:0] out_column;
        logic                 frame_last;
    } result_t;

    // position data carried alongside a pixel through the pipeline
    typedef struct packed {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] column;
        logic                 last;
    } meta_t;

    // line buffer port control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } lb_ctrl_t;

endpackage

### sv/rgb_median_window_filter.sv
// ----------------------------------------------------------------------------
// rgb median window filter
// per-channel median over a square window of a raster-order rgb stream
// ----------------------------------------------------------------------------
// Takes one pixel per clock and gives one result per clock for every pixel
// whose window lies wholly inside the frame; border pixels give no result.
// The previous lines sit in a single memory word per column, read and
// written back once per pixel, which sets the rate. A result passes the
// line read, window shift, compare and rank count registers on its way to
// the output register. The input stalls only while a result waits in the
// output register. The user must write width and height through the
// configuration port only between frames; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "rgb_median_window_filter_macros.svh"

module rgb_median_window_filter #(
    parameter int WINDOW    = rmwf_pkg::DEFAULT_WINDOW,
    parameter int MAX_WIDTH = rmwf_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [rmwf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rmwf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rmwf_pkg::pixel_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rmwf_pkg::result_t                   out_data
);
    import rmwf_pkg::*;

    localparam int TAPS   = WINDOW * WINDOW;
    localparam int HALF   = WINDOW / 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int LINE_W = (WINDOW - 1) * PIXEL_W;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [COL_W-1:0]        col_count_reg;
    logic [ROW_W-1:0]        row_count_reg;

    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic              col_end;
    logic              row_end;
    logic              accept;
    logic              advance;

    logic                s1_valid_reg;
    logic                s1_res_reg;
    logic [PIXEL_W-1:0]  s1_pix_reg;
    logic [COL_W-1:0]    s1_col_reg;
    meta_t               s1_meta_reg;
    logic [COL_W-1:0]    col_diff;
    logic [ROW_W-1:0]    row_diff;

    lb_ctrl_t            lb_ctrl;
    logic [LINE_W-1:0]   line_rd;
    logic [LINE_W-1:0]   line_wr;
    logic [WINDOW-1:0][PIXEL_W-1:0] colv;

    logic [TAPS-1:0][PIXEL_W-1:0] win_reg;
    logic [TAPS-1:0][CHAN_W-1:0]  win_red;
    logic [TAPS-1:0][CHAN_W-1:0]  win_green;
    logic [TAPS-1:0][CHAN_W-1:0]  win_blue;

    logic  w_valid_reg;
    logic  a_valid_reg;
    logic  b_valid_reg;
    meta_t w_meta_reg;
    meta_t a_meta_reg;
    meta_t b_meta_reg;

    logic [CHAN_W-1:0] med_red;
    logic [CHAN_W-1:0] med_green;
    logic [CHAN_W-1:0] med_blue;

    logic    out_valid_reg;
    result_t out_data_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_REG_W'(WIDTH_RESET);
            height_reg <= HEIGHT_REG_W'(HEIGHT_RESET);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped to the supported range
    always_comb
    begin
        width_eff = SIZE_W'(width_reg);
        if (width_reg == '0)
        begin
            width_eff = SIZE_W'(1);
        end
        else if (SIZE_W'(width_reg) > SIZE_W'(MAX_WIDTH))
        begin
            width_eff = SIZE_W'(MAX_WIDTH);
        end
        height_eff = height_reg;
        if (height_reg == '0)
        begin
            height_eff = SIZE_W'(1);
        end
        else if (height_reg > SIZE_W'(HEIGHT_LIMIT))
        begin
            height_eff = SIZE_W'(HEIGHT_LIMIT);
        end
    end

    assign col_end  = SIZE_W'(col_count_reg) >= (width_eff - SIZE_W'(1));
    assign row_end  = SIZE_W'(row_count_reg) >= (height_eff - SIZE_W'(1));
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;
    assign accept   = in_valid && advance;
    assign col_diff = col_count_reg - COL_W'(HALF);
    assign row_diff = row_count_reg - ROW_W'(HALF);

    // raster position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_count_reg <= '0;
                row_count_reg <= row_end ? '0 : row_count_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= col_count_reg + COL_W'(1);
            end
        end
    end

    // first stage: pixel captured while its column is read from the line buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg         <= in_data;
            s1_col_reg         <= col_count_reg;
            s1_res_reg         <= (row_count_reg >= ROW_W'(WINDOW - 1))
                               && (col_count_reg >= COL_W'(WINDOW - 1));
            s1_meta_reg.row    <= row_diff;
            s1_meta_reg.column <= OUT_COL_W'(col_diff);
            s1_meta_reg.last   <= row_end && col_end;
        end
    end

    assign lb_ctrl.rd_en = accept;
    assign lb_ctrl.wr_en = s1_valid_reg && advance;

    rmwf_line_buffer #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (LINE_W)
    ) u_line_buffer (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lb_ctrl),
        .rd_addr (col_count_reg),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr),
        .rd_data (line_rd)
    );

    // column vector: oldest line first, new pixel last; write back shifted up
    always_comb
    begin
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            colv[k] = line_rd[k*PIXEL_W +: PIXEL_W];
        end
        colv[WINDOW-1] = s1_pix_reg;
        for (int k = 0; k < WINDOW - 1; k++)
        begin
            line_wr[k*PIXEL_W +: PIXEL_W] = colv[k+1];
        end
    end

    // window shift with the new column entering on the right
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            for (int r = 0; r < WINDOW; r++)
            begin
                for (int c = 0; c < WINDOW - 1; c++)
                begin
                    win_reg[r*WINDOW+c] <= win_reg[r*WINDOW+c+1];
                end
                win_reg[r*WINDOW+WINDOW-1] <= colv[r];
            end
        end
    end

    // channel split of the window taps
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            win_red[t]   = win_reg[t][3*CHAN_W-1:2*CHAN_W];
            win_green[t] = win_reg[t][2*CHAN_W-1:CHAN_W];
            win_blue[t]  = win_reg[t][CHAN_W-1:0];
        end
    end

    rmwf_median #(.TAPS(TAPS)) u_median_red (
        .clk    (clk),
        .en     (advance),
        .values (win_red),
        .median (med_red)
    );

    rmwf_median #(.TAPS(TAPS)) u_median_green (
        .clk    (clk),
        .en     (advance),
        .values (win_green),
        .median (med_green)
    );

    rmwf_median #(.TAPS(TAPS)) u_median_blue (
        .clk    (clk),
        .en     (advance),
        .values (win_blue),
        .median (med_blue)
    );

    // result valid flags along the median pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w_valid_reg   <= s1_valid_reg && s1_res_reg;
            a_valid_reg   <= w_valid_reg;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    // position data and output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w_meta_reg <= s1_meta_reg;
            a_meta_reg <= w_meta_reg;
            b_meta_reg <= a_meta_reg;
            if (b_valid_reg)
            begin
                out_data_reg.median_red   <= med_red;
                out_data_reg.median_green <= med_green;
                out_data_reg.median_blue  <= med_blue;
                out_data_reg.out_row      <= b_meta_reg.row;
                out_data_reg.out_column   <= b_meta_reg.column;
                out_data_reg.frame_last   <= b_meta_reg.last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    `RMWF_ASSERT_NOW(a_no_accept_on_stall, clk, rst_n, out_valid && !out_ready, !in_ready, "pixel accepted while result stalled")
    `RMWF_ASSERT_NEXT(a_col_wrap, clk, rst_n, accept && col_end, col_count_reg == '0, "column counter did not wrap")
    `RMWF_ASSERT_NOW(a_result_source, clk, rst_n, $rose(out_valid_reg), $past(b_valid_reg), "result without a pipelined window")

endmodule

### sv/rmwf_line_buffer.sv
// ----------------------------------------------------------------------------
// rmwf line buffer
// one word per column holding the previous lines, registered read,
// with forwarding of a write to the same column in the cycle of the read
// ----------------------------------------------------------------------------
module rmwf_line_buffer #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 96
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmwf_pkg::lb_ctrl_t   ctrl,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]    wr_data,
    output logic [DATA_W-1:0]    rd_data
);
    import rmwf_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    // memory write port
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // memory read port, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            rdata_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // bypass flag for a read that collides with the write of the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (ctrl.rd_en)
        begin
            fwd_reg <= ctrl.wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : rdata_reg;

endmodule

### sv/rmwf_median.sv
// ----------------------------------------------------------------------------
// rmwf median
// pipelined rank selection of the middle value of one colour channel:
// compare matrix, then rank counts, then selection
// ----------------------------------------------------------------------------
module rmwf_median #(
    parameter int TAPS = 25
) (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [TAPS-1:0][rmwf_pkg::CHAN_W-1:0]  values,
    output logic [rmwf_pkg::CHAN_W-1:0]            median
);
    import rmwf_pkg::*;

    localparam int MID   = TAPS / 2;
    localparam int CNT_W = $clog2(TAPS + 1);

    logic [TAPS-1:0][CHAN_W-1:0] val_a_reg;
    logic [TAPS-1:0][TAPS-1:0]   lt_a_reg;
    logic [TAPS-1:0][TAPS-1:0]   gt_a_reg;
    logic [TAPS-1:0][TAPS-1:0]   lt_next;
    logic [TAPS-1:0][TAPS-1:0]   gt_next;
    logic [TAPS-1:0][CHAN_W-1:0] val_b_reg;
    logic [TAPS-1:0][CNT_W-1:0]  below_b_reg;
    logic [TAPS-1:0][CNT_W-1:0]  above_b_reg;
    logic [TAPS-1:0][CNT_W-1:0]  below_next;
    logic [TAPS-1:0][CNT_W-1:0]  above_next;

    // pairwise comparisons
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                lt_next[i][j] = values[j] < values[i];
                gt_next[i][j] = values[j] > values[i];
            end
        end
    end

    // rank counts
    always_comb
    begin
        for (int i = 0; i < TAPS; i++)
        begin
            below_next[i] = CNT_W'($countones(lt_a_reg[i]));
            above_next[i] = CNT_W'($countones(gt_a_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_a_reg   <= values;
            lt_a_reg    <= lt_next;
            gt_a_reg    <= gt_next;
            val_b_reg   <= val_a_reg;
            below_b_reg <= below_next;
            above_b_reg <= above_next;
        end
    end

    // every tap holding the middle rank has the same value, so an or is enough
    always_comb
    begin
        median = '0;
        for (int i = 0; i < TAPS; i++)
        begin
            if ((below_b_reg[i] <= CNT_W'(MID)) && (above_b_reg[i] < CNT_W'(TAPS - MID)))
            begin
                median = median | val_b_reg[i];
            end
        end
    end

endmodule

### tb/tb_rgb_median_window_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb median window filter testbench
// ----------------------------------------------------------------------------
// Streams whole frames of several sizes through the filter, predicts every
// interior 5x5 per-channel median with row, column and end-of-frame flag,
// and checks each output transaction in order. Width and height are only
// changed between frames, once the filter has drained. Source gaps and sink
// stalls vary from frame to frame.
// ----------------------------------------------------------------------------
module tb_rgb_median_window_filter;
    import rmwf_pkg::*;

    localparam int WIN       = 5;
    localparam int LINE_MAX  = 2048;
    localparam int DRAIN     = 12;
    localparam int STALL_MAX = 5000;

    // median predictor and store of expected medians
    class median_scoreboard;
        pixel_t      lines [WIN-1][LINE_MAX];
        pixel_t      win [WIN][WIN];
        int unsigned col_cnt;
        int unsigned row_cnt;
        int unsigned width_reg;
        int unsigned height_reg;
        result_t     pending_medians [$];
        int          mismatches;
        int          matched;

        function new();
            col_cnt    = 0;
            row_cnt    = 0;
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            mismatches = 0;
            matched    = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
            if (idx == REG_IMAGE_WIDTH)
                width_reg = value & 12'hFFF;
            else
                height_reg = value & 13'h1FFF;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0)
                return 1;
            return (width_reg > LINE_MAX) ? LINE_MAX : width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0)
                return 1;
            return (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg;
        endfunction

        // element 12 of the sorted window values of one channel
        function logic [7:0] channel_median(int sel);
            int vals [WIN*WIN];
            int t;
            int tmp;
            t = 0;
            for (int r = 0; r < WIN; r++)
                for (int c = 0; c < WIN; c++)
                begin
                    vals[t] = (sel == 0) ? win[r][c].pixel_red :
                              (sel == 1) ? win[r][c].pixel_green : win[r][c].pixel_blue;
                    t++;
                end
            for (int i = 1; i < WIN*WIN; i++)
                for (int j = i; j > 0 && vals[j-1] > vals[j]; j--)
                begin
                    tmp       = vals[j];
                    vals[j]   = vals[j-1];
                    vals[j-1] = tmp;
                end
            return vals[(WIN*WIN)/2][7:0];
        endfunction

        // accepted pixel: update line store and window, queue a median if interior
        function void note_pixel(pixel_t p);
            pixel_t      column [WIN];
            int unsigned w;
            int unsigned h;
            result_t     res;
            w = eff_width();
            h = eff_height();
            for (int k = 0; k < WIN-1; k++)
                column[k] = lines[k][col_cnt % LINE_MAX];
            column[WIN-1] = p;
            for (int k = 0; k < WIN-1; k++)
                lines[k][col_cnt % LINE_MAX] = column[k+1];
            for (int r = 0; r < WIN; r++)
            begin
                for (int c = 0; c < WIN-1; c++)
                    win[r][c] = win[r][c+1];
                win[r][WIN-1] = column[r];
            end
            if (row_cnt >= WIN-1 && col_cnt >= WIN-1)
            begin
                res.median_red   = channel_median(0);
                res.median_green = channel_median(1);
                res.median_blue  = channel_median(2);
                res.out_row      = ROW_W'(row_cnt - WIN/2);
                res.out_column   = OUT_COL_W'(col_cnt - WIN/2);
                res.frame_last   = (row_cnt >= h-1) && (col_cnt >= w-1);
                pending_medians.push_back(res);
            end
            if (col_cnt >= w-1)
            begin
                col_cnt = 0;
                row_cnt = (row_cnt >= h-1) ? 0 : ((row_cnt + 1) & 12'hFFF);
            end
            else
                col_cnt++;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        // output transaction: compare against the oldest expected median
        task check_result(result_t got);
            result_t want;
            if (pending_medians.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_medians.pop_front();
            if (got.median_red !== want.median_red)
                report($sformatf("red %0d, expected %0d", got.median_red, want.median_red));
            if (got.median_green !== want.median_green)
                report($sformatf("green %0d, expected %0d",
                                 got.median_green, want.median_green));
            if (got.median_blue !== want.median_blue)
                report($sformatf("blue %0d, expected %0d", got.median_blue, want.median_blue));
            if (got.out_row !== want.out_row)
                report($sformatf("row %0d, expected %0d", got.out_row, want.out_row));
            if (got.out_column !== want.out_column)
                report($sformatf("column %0d, expected %0d", got.out_column, want.out_column));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last %0b, expected %0b",
                                 got.frame_last, want.frame_last));
            matched++;
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    pixel_t                 in_data;
    logic                   out_valid;
    logic                   out_ready;
    result_t                out_data;

    median_scoreboard sb;
    int src_gap_pct;
    int sink_stall_pct;
    int pixels_sent;
    int frames_sent;
    int quiet_cycles;

    rgb_median_window_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side: random stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    // result checking
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("timeout with %0d results outstanding", sb.pending_medians.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // one pixel transaction, with random source gaps beforehand
    task send_pixel(pixel_t p);
        while ($urandom_range(99) < src_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_pixel(p);
        pixels_sent++;
        @(negedge clk);
    endtask

    // register write once the filter has drained
    task write_register(logic [CFG_INDEX_W-1:0] idx, int unsigned value);
        while (sb.pending_medians.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        sb.set_register(idx, value);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // pixel content: random, all black, all white, or a few repeated levels
    function pixel_t make_pixel(int mode);
        pixel_t p;
        p = pixel_t'($urandom());
        case (mode)
            1: p = '0;
            2: p = '1;
            3:
            begin
                p.pixel_red   = ($urandom_range(2) == 0) ? 8'h00 : 8'hFF;
                p.pixel_green = ($urandom_range(1) == 0) ? 8'h80 : 8'hFF;
                p.pixel_blue  = ($urandom_range(2) == 0) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return p;
    endfunction

    // a complete frame at the given register values; idling varies per frame
    task send_frame(int unsigned w, int unsigned h, int mode);
        int unsigned n;
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
        case (frames_sent % 5)
            0: begin src_gap_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_gap_pct = 49; sink_stall_pct = 0;  end
            2: begin src_gap_pct = 0;  sink_stall_pct = 49; end
            3: begin src_gap_pct = 17; sink_stall_pct = 17; end
            default: begin src_gap_pct = 0; sink_stall_pct = 0; end
        endcase
        n = sb.eff_width() * sb.eff_height();
        for (int unsigned i = 0; i < n; i++)
            send_pixel(make_pixel(mode));
        in_valid = 1'b0;
        frames_sent++;
    endtask

    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_IMAGE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b1;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        pixels_sent    = 0;
        frames_sent    = 0;
        quiet_cycles   = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: smallest frames, degenerate sizes, flat content
        send_frame(0, 0, 0);
        send_frame(1, 1, 2);
        send_frame(5, 5, 2);
        send_frame(5, 5, 1);
        send_frame(5, 5, 3);
        send_frame(6, 4, 0);

        // random frames, mostly small
        while (pixels_sent < 1050)
            send_frame($urandom_range(12, 5), $urandom_range(10, 5), $urandom_range(4) % 4);

        while (sb.pending_medians.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("%0d frames, %0d pixels, %0d medians checked, sizes 1x1 up to 12x10",
                 frames_sent, pixels_sent, sb.matched);
        if (sb.mismatches == 0 && sb.pending_medians.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
